// ----- rtl/tag_hash_table_engine_defines.svh -----
`ifndef TAG_HASH_TABLE_ENGINE_DEFINES_SVH
`define TAG_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define THTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tag hash table check failed");

// Next-cycle implication, checked out of reset.
`define THTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tag hash table check failed");

`endif

// ----- rtl/thte_pkg.sv -----
package thte_pkg;

  localparam int TAG_W      = 32;
  localparam int HANDLE_W   = 16;
  localparam int CNT_OUT_W  = 13;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                wr;
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [1:0]          status;
    logic                inc;
    logic                dec;
  } bkt_res_t;

endpackage

// ----- rtl/thte_ram.sv -----
module thte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  assign rdata = rd_q_r;

endmodule

// ----- rtl/thte_bucket.sv -----
module thte_bucket import thte_pkg::*; #(
  parameter int WAYS = 4
) (
  input  cmd_e                cmd,
  input  logic [TAG_W-1:0]    tag,
  input  logic [HANDLE_W-1:0] handle,
  input  entry_t [WAYS-1:0]   row_in,
  output entry_t [WAYS-1:0]   row_out,
  output bkt_res_t            res
);

  logic [WAYS-1:0] lk_hit;
  logic [WAYS-1:0] del_hit;
  logic [WAYS-1:0] past;
  logic [HANDLE_W-1:0] lk_handle;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lk_hit[w]  = row_in[w].valid && (row_in[w].tag == tag);
      del_hit[w] = lk_hit[w] && (row_in[w].handle == handle);
    end
  end

  // newest match wins: lowest way index
  always_comb begin
    lk_handle = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lk_hit[w]) begin
        lk_handle = row_in[w].handle;
      end
    end
  end

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      seen    = seen | del_hit[w];
      past[w] = seen;
    end
  end

  always_comb begin
    row_out = row_in;
    res     = '0;
    case (cmd)
      CMD_LOOKUP: begin
        res.found        = |lk_hit;
        res.found_handle = lk_handle;
        res.status       = (|lk_hit) ? ST_OK : ST_MISS;
      end
      CMD_ADD: begin
        if (row_in[WAYS-1].valid) begin
          res.status = ST_FULL;
        end else begin
          for (int k = 1; k < WAYS; k++) begin
            row_out[k] = row_in[k-1];
          end
          row_out[0].valid  = 1'b1;
          row_out[0].tag    = tag;
          row_out[0].handle = handle;
          res.wr  = 1'b1;
          res.inc = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (past[WAYS-1]) begin
          for (int k = 0; k < WAYS - 1; k++) begin
            if (past[k]) begin
              row_out[k] = row_in[k+1];
            end
          end
          row_out[WAYS-1] = '0;
          res.wr    = 1'b1;
          res.dec   = 1'b1;
          res.found = 1'b1;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- rtl/tag_hash_table_engine.sv -----
// Result path: the bucket row is read into the table RAM output register at the input edge;
// in S_EXEC, once the output register is free, the row is updated and the result registered.
// A new item is taken only in S_IDLE, after the previous one has produced its result; each
// item needs the read and write-back of one bucket row in the single table RAM.
// Reset: synchronous; afterwards the table RAM is zeroed one bucket per cycle across all
// BUCKETS rows (1024 by default), with in_tready low until the sweep ends.
module tag_hash_table_engine import thte_pkg::*; #(
  parameter int BUCKETS = 1024,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [47:0] in_tdata,   // tag[31:0], handle[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // found[0], found_handle[16:1], status[18:17],
                                  // entry_count[31:19]
);

  `include "tag_hash_table_engine_defines.svh"

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ROW_W  = WAYS * $bits(entry_t);
  localparam int SLOTS  = BUCKETS * WAYS;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [15:0] HASH_MASK = 16'(BUCKETS - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r, out_data_nxt;
  cmd_e                 cmd_r, cmd_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;

  logic                 in_fire;
  logic                 go;
  logic [15:0]          hash;
  logic [IDX_W-1:0]     in_idx;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic [ROW_W-1:0]     ram_rdata;
  entry_t [WAYS-1:0]    row_rd;
  entry_t [WAYS-1:0]    row_wr;
  bkt_res_t             res;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign go        = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign hash   = in_tdata[31:16] ^ {8'd0, in_tdata[31:24]};
  assign in_idx = IDX_W'(hash & HASH_MASK);

  assign row_rd = ram_rdata;

  thte_bucket #(
    .WAYS(WAYS)
  ) u_bucket (
    .cmd     (cmd_r),
    .tag     (tag_r),
    .handle  (handle_r),
    .row_in  (row_rd),
    .row_out (row_wr),
    .res     (res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = row_wr;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (go) begin
      ram_we = res.wr;
    end
  end

  thte_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd_nxt       = cmd_r;
    tag_nxt       = tag_r;
    handle_nxt    = handle_r;
    idx_nxt       = idx_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt    = cmd_e'(in_tuser);
          tag_nxt    = in_tdata[31:0];
          handle_nxt = in_tdata[47:32];
          idx_nxt    = in_idx;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          if (res.inc) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if (res.dec && (cnt_r != '0)) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          out_data_nxt  = {CNT_OUT_W'(cnt_nxt), res.status, res.found_handle, res.found};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      cmd_r       <= cmd_nxt;
      tag_r       <= tag_nxt;
      handle_r    <= handle_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `THTE_ASSERT_NXT(a_fire_to_exec, in_fire, state_r == S_EXEC)
  `THTE_ASSERT_IMP(a_we_when_free, ram_we && (state_r != S_CLEAR),
                   (state_r == S_EXEC) && (!out_valid_r || out_tready))
  `THTE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(SLOTS))
  `THTE_ASSERT_IMP(a_result_from_exec, $rose(out_valid_r), $past(state_r) == S_EXEC)

endmodule
